// ----- hw/rtl/bmfb_pkg.sv -----
// Shared types and constants for the bicolor matrix frame buffer.
// Holds operation codes and fixed widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bmfb_pkg;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 3;
  localparam int COLOR_W  = 2;
  localparam int WORD_W   = 16;
  localparam int DRIVE_W  = 8;
  localparam int ADDR_W   = 4;
  localparam int MEM_DEPTH = 16;
  localparam int SHIFT_W  = 4;
  localparam int HALF_W   = 8;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_WRPIX   = 3'd0;
  localparam kind_t KIND_RDPIX   = 3'd1;
  localparam kind_t KIND_CLEAR   = 3'd2;
  localparam kind_t KIND_SWAP    = 3'd3;
  localparam kind_t KIND_WRCOL   = 3'd4;
  localparam kind_t KIND_RDBACK  = 3'd5;
  localparam kind_t KIND_RDFRONT = 3'd6;
  localparam kind_t KIND_DRIVE   = 3'd7;

endpackage
`default_nettype wire

// ----- hw/rtl/bicolor_matrix_frame_buffer.sv -----
// Single-beat operations give one output beat; a write pixel within range first does a read-
// modify-write, a swap with copy reads and then writes each column of the new front bank into
// the back bank in turn, and a column drive gives seventeen beats: sixteen shift, one latch.
// Throughput: one item at a time; a new item is taken once the previous one has produced
// its last beat into the output register. Reset clears all words (valid bits), makes
// bank one the front bank and zeroes the column drive register.
`timescale 1ns / 1ps
`default_nettype none
module bicolor_matrix_frame_buffer #(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bmfb_pkg::KIND_W-1:0]   kind,
  input  wire logic [bmfb_pkg::INDEX_W-1:0]  column,
  input  wire logic [bmfb_pkg::INDEX_W-1:0]  row,
  input  wire logic [bmfb_pkg::COLOR_W-1:0]  color,
  input  wire logic                          inherit,
  input  wire logic [bmfb_pkg::WORD_W-1:0]   word_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bmfb_pkg::COLOR_W-1:0]       color_out,
  output logic [bmfb_pkg::WORD_W-1:0]        word_out,
  output logic                               serial_bit,
  output logic                               latch,
  output logic [bmfb_pkg::DRIVE_W-1:0]       column_drive,
  output logic                               last
);
  import bmfb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_CPRD  = 3'd3;
  localparam logic [2:0] S_CPWR  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_LATCH = 3'd6;

  logic [2:0]           state;
  logic [SHIFT_W-1:0]   cnt;
  kind_t                op;
  logic [INDEX_W-1:0]   col;
  logic [INDEX_W-1:0]   rw;
  logic [COLOR_W-1:0]   pix;
  logic [WORD_W-1:0]    word;
  logic                 col_ok;
  logic                 row_ok;
  logic                 front_select;
  logic [DRIVE_W-1:0]   drive_reg;

  logic [WORD_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld;
  logic [WORD_W-1:0]    rd_data;
  logic                 rd_vld;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [WORD_W-1:0]    wdata;
  logic                 we;

  logic                 accept;
  logic                 out_free;
  logic                 emit;
  logic                 in_col_ok;
  logic                 in_row_ok;
  logic [WORD_W-1:0]    cur;
  logic [WORD_W-1:0]    lo_mask;
  logic [WORD_W-1:0]    hi_mask;
  logic [WORD_W-1:0]    pix_word;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign emit      = out_free && (state == S_EMIT || state == S_SHIFT || state == S_LATCH);
  assign in_col_ok = ({1'b0, column} < 4'(COLUMNS));
  assign in_row_ok = ({1'b0, row} < 4'(ROWS));
  assign cur       = rd_vld ? rd_data : '0;
  assign lo_mask   = 16'(1) << rw;
  assign hi_mask   = 16'(1) << ({1'b0, rw} + 4'(HALF_W));

  always_comb begin
    pix_word = cur & ~(lo_mask | hi_mask);
    if (pix[1]) begin
      pix_word = pix_word | hi_mask;
    end
    if (pix[0]) begin
      pix_word = pix_word | lo_mask;
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE: begin
        raddr = (kind == KIND_RDFRONT) ? {front_select, column} : {~front_select, column};
      end
      S_CPRD: raddr = {front_select, cnt[INDEX_W-1:0]};
      default: raddr = (op == KIND_RDFRONT) ? {front_select, col} : {~front_select, col};
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = {~front_select, col};
    wdata = word;
    unique case (state)
      S_IDLE: begin
        we    = accept && (kind == KIND_WRCOL) && in_col_ok;
        waddr = {~front_select, column};
        wdata = word_in;
      end
      S_RMW: begin
        we    = 1'b1;
        wdata = pix_word;
      end
      S_CPWR: begin
        we    = 1'b1;
        waddr = {~front_select, cnt[INDEX_W-1:0]};
        wdata = cur;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[raddr];
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (accept && kind == KIND_CLEAR) begin
        for (int i = 0; i < HALF_W; i++) begin
          vld[{~front_select, INDEX_W'(i)}] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= kind;
      col    <= column;
      rw     <= row;
      pix    <= color;
      word   <= word_in;
      col_ok <= in_col_ok;
      row_ok <= in_row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      front_select <= 1'b1;
      drive_reg    <= '0;
      out_valid    <= 1'b0;
      color_out    <= '0;
      word_out     <= '0;
      serial_bit   <= 1'b0;
      latch        <= 1'b0;
      column_drive <= '0;
      last         <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            unique case (kind)
              KIND_WRPIX: state <= (in_col_ok && in_row_ok) ? S_RMW : S_EMIT;
              KIND_SWAP: begin
                front_select <= ~front_select;
                state        <= inherit ? S_CPRD : S_EMIT;
              end
              KIND_DRIVE: state <= S_SHIFT;
              default: state <= S_EMIT;
            endcase
          end
        end
        S_RMW: state <= S_EMIT;
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          cnt <= cnt + 1'b1;
          if (cnt[INDEX_W-1:0] == INDEX_W'(COLUMNS - 1)) begin
            state <= S_EMIT;
          end else begin
            state <= S_CPRD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            color_out    <= '0;
            word_out     <= '0;
            serial_bit   <= 1'b0;
            latch        <= 1'b0;
            column_drive <= drive_reg;
            last         <= 1'b1;
            if (op == KIND_RDPIX && col_ok && row_ok) begin
              color_out <= {cur[{1'b0, rw} + 4'(HALF_W)], cur[rw]};
            end
            if ((op == KIND_RDBACK || op == KIND_RDFRONT) && col_ok) begin
              word_out <= cur;
            end
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (out_free) begin
            color_out    <= '0;
            word_out     <= '0;
            serial_bit   <= ~word[cnt];
            latch        <= 1'b0;
            column_drive <= drive_reg;
            last         <= 1'b0;
            cnt          <= cnt + 1'b1;
            if (cnt == '1) begin
              state <= S_LATCH;
            end
          end
        end
        S_LATCH: begin
          if (out_free) begin
            color_out    <= '0;
            word_out     <= '0;
            serial_bit   <= 1'b0;
            latch        <= 1'b1;
            column_drive <= DRIVE_W'(1) << col;
            drive_reg    <= DRIVE_W'(1) << col;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_latch_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && latch |-> $onehot(column_drive) && last && !serial_bit)
    else $error("latch beat malformed");

  a_shift_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && serial_bit |-> !last && !latch && (word_out == '0))
    else $error("shift beat malformed");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start");

  a_drive_tracks: assert property (@(posedge clk) disable iff (rst)
    state == S_LATCH && out_free |=> drive_reg == column_drive)
    else $error("drive register out of step with port");

endmodule
`default_nettype wire

// ----- tb/bicolor_matrix_frame_buffer_test.sv -----
// Self-checking testbench for the bicolor matrix frame buffer: a bank and drive predictor
// checks every output beat against the block's ports. Depends on bmfb_pkg and the RTL.
`timescale 1ns / 1ps
module bicolor_matrix_frame_buffer_test;
  import bmfb_pkg::*;

  localparam int COLS          = 8;
  localparam int ROWS_N        = 8;
  localparam int RANDOM_ITEMS  = 450;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 200;

  typedef struct {
    kind_t               kind;
    logic [INDEX_W-1:0]  column;
    logic [INDEX_W-1:0]  row;
    logic [COLOR_W-1:0]  color;
    logic                inherit;
    logic [WORD_W-1:0]   word;
  } frame_op_t;

  typedef struct {
    logic [COLOR_W-1:0]  color_out;
    logic [WORD_W-1:0]   word_out;
    logic                serial_bit;
    logic                latch;
    logic [DRIVE_W-1:0]  column_drive;
    logic                last;
  } beat_t;

  class frame_buffer_model;
    logic [WORD_W-1:0]  bank [MEM_DEPTH];
    bit                 front_is_one;
    logic [DRIVE_W-1:0] drive_port;
    beat_t              expected_beats[$];
    int                 errors;

    function new();
      foreach (bank[i]) bank[i] = '0;
      front_is_one = 1'b1;
      drive_port   = '0;
      errors       = 0;
    endfunction

    function void note_item(frame_op_t op);
      int                back_at;
      int                front_at;
      logic [WORD_W-1:0] w;
      beat_t             b;
      back_at  = front_is_one ? 0 : COLS;
      front_at = front_is_one ? COLS : 0;
      b = '{default: '0};
      b.last = 1'b1;
      if (op.kind == KIND_DRIVE) begin
        for (int i = 0; i < WORD_W; i++) begin
          beat_t s;
          s = '{default: '0};
          s.serial_bit   = ~op.word[i];
          s.column_drive = drive_port;
          expected_beats.push_back(s);
        end
        drive_port     = 8'b1 << op.column;
        b.latch        = 1'b1;
        b.column_drive = drive_port;
        expected_beats.push_back(b);
        return;
      end
      case (op.kind)
        KIND_WRPIX: begin
          if (op.column < COLS && op.row < ROWS_N) begin
            w = bank[back_at + op.column];
            w[op.row + 8] = op.color[1];
            w[op.row]     = op.color[0];
            bank[back_at + op.column] = w;
          end
        end
        KIND_RDPIX: begin
          if (op.column < COLS && op.row < ROWS_N) begin
            w = bank[back_at + op.column];
            b.color_out = {w[op.row + 8], w[op.row]};
          end
        end
        KIND_CLEAR: begin
          for (int i = 0; i < COLS; i++) bank[back_at + i] = '0;
        end
        KIND_SWAP: begin
          front_is_one = ~front_is_one;
          if (op.inherit) begin
            back_at  = front_is_one ? 0 : COLS;
            front_at = front_is_one ? COLS : 0;
            for (int i = 0; i < COLS; i++) bank[back_at + i] = bank[front_at + i];
          end
        end
        KIND_WRCOL: begin
          if (op.column < COLS) bank[back_at + op.column] = op.word;
        end
        KIND_RDBACK: begin
          if (op.column < COLS) b.word_out = bank[back_at + op.column];
        end
        KIND_RDFRONT: begin
          if (op.column < COLS) b.word_out = bank[front_at + op.column];
        end
        default: ;
      endcase
      b.column_drive = drive_port;
      expected_beats.push_back(b);
    endfunction

    function void report(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, exp_v, got_v);
    endfunction

    function void check_beat(beat_t got);
      beat_t exp_b;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("unexpected beat with no item pending");
        return;
      end
      exp_b = expected_beats.pop_front();
      if (got.color_out !== exp_b.color_out)
        report("color_out", WORD_W'(exp_b.color_out), WORD_W'(got.color_out));
      if (got.word_out !== exp_b.word_out)
        report("word_out", exp_b.word_out, got.word_out);
      if (got.serial_bit !== exp_b.serial_bit)
        report("serial_bit", WORD_W'(exp_b.serial_bit), WORD_W'(got.serial_bit));
      if (got.latch !== exp_b.latch)
        report("latch", WORD_W'(exp_b.latch), WORD_W'(got.latch));
      if (got.column_drive !== exp_b.column_drive)
        report("column_drive", WORD_W'(exp_b.column_drive), WORD_W'(got.column_drive));
      if (got.last !== exp_b.last)
        report("last", WORD_W'(exp_b.last), WORD_W'(got.last));
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind      = '0;
  logic [INDEX_W-1:0]  column    = '0;
  logic [INDEX_W-1:0]  row       = '0;
  logic [COLOR_W-1:0]  color     = '0;
  logic                inherit   = 1'b0;
  logic [WORD_W-1:0]   word_in   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COLOR_W-1:0]  color_out;
  logic [WORD_W-1:0]   word_out;
  logic                serial_bit;
  logic                latch;
  logic [DRIVE_W-1:0]  column_drive;
  logic                last;

  logic                steady    = 1'b0;
  int                  cycle_count = 0;
  frame_buffer_model   model = new();

  bicolor_matrix_frame_buffer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS_N)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .column      (column),
    .row         (row),
    .color       (color),
    .inherit     (inherit),
    .word_in     (word_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .color_out   (color_out),
    .word_out    (word_out),
    .serial_bit  (serial_bit),
    .latch       (latch),
    .column_drive(column_drive),
    .last        (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** bicolor_matrix_frame_buffer: FAILED **");
      $finish;
    end
  end

  // stall the output side at random, except during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.color_out    = color_out;
      got.word_out     = word_out;
      got.serial_bit   = serial_bit;
      got.latch        = latch;
      got.column_drive = column_drive;
      got.last         = last;
      model.check_beat(got);
    end
  end

  function automatic frame_op_t make_op(kind_t k, int col, int r, int c, bit inh, int w);
    frame_op_t op;
    op.kind    = k;
    op.column  = INDEX_W'(col);
    op.row     = INDEX_W'(r);
    op.color   = COLOR_W'(c);
    op.inherit = inh;
    op.word    = WORD_W'(w);
    return op;
  endfunction

  function automatic frame_op_t random_op();
    frame_op_t op;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 25)      op.kind = KIND_WRPIX;
    else if (pick < 45) op.kind = KIND_RDPIX;
    else if (pick < 50) op.kind = KIND_CLEAR;
    else if (pick < 60) op.kind = KIND_SWAP;
    else if (pick < 70) op.kind = KIND_WRCOL;
    else if (pick < 80) op.kind = KIND_RDBACK;
    else if (pick < 88) op.kind = KIND_RDFRONT;
    else                op.kind = KIND_DRIVE;
    op.column  = INDEX_W'($urandom_range(7));
    op.row     = INDEX_W'($urandom_range(7));
    op.color   = COLOR_W'($urandom_range(3));
    op.inherit = 1'($urandom_range(1));
    op.word    = WORD_W'($urandom_range(16'hFFFF));
    return op;
  endfunction

  task automatic send_item(frame_op_t op);
    kind     <= op.kind;
    column   <= op.column;
    row      <= op.row;
    color    <= op.color;
    inherit  <= op.inherit;
    word_in  <= op.word;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model.note_item(op);
  endtask

  task automatic idle_gap(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (model.expected_beats.size() != 0);
  endtask

  initial begin
    frame_op_t directed[$];
    directed.push_back(make_op(KIND_WRPIX,   0, 0, 3, 0, 16'h0000));
    directed.push_back(make_op(KIND_WRPIX,   7, 7, 2, 1, 16'hFFFF));
    directed.push_back(make_op(KIND_WRPIX,   3, 4, 1, 0, 16'h1234));
    directed.push_back(make_op(KIND_RDPIX,   0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDPIX,   7, 7, 3, 1, 16'hFFFF));
    directed.push_back(make_op(KIND_RDPIX,   3, 4, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_WRPIX,   0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDPIX,   0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_WRCOL,   7, 0, 0, 0, 16'hFFFF));
    directed.push_back(make_op(KIND_WRCOL,   0, 0, 0, 0, 16'h8001));
    directed.push_back(make_op(KIND_RDBACK,  7, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDFRONT, 7, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_SWAP,    0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDFRONT, 7, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDBACK,  7, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_WRCOL,   5, 0, 0, 0, 16'hA5C3));
    directed.push_back(make_op(KIND_SWAP,    0, 0, 0, 1, 16'h0000));
    directed.push_back(make_op(KIND_RDBACK,  5, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDFRONT, 0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_CLEAR,   0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDBACK,  5, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_RDFRONT, 5, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_DRIVE,   0, 0, 0, 0, 16'h0000));
    directed.push_back(make_op(KIND_DRIVE,   7, 7, 3, 1, 16'hFFFF));
    directed.push_back(make_op(KIND_DRIVE,   3, 0, 0, 0, 16'h5A3C));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if ($urandom_range(99) < 13) idle_gap($urandom_range(1, 4));
      send_item(directed[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= 150 && n < 260);
      if (n == 300) drain_results();
      if (!(n >= 150 && n < 260) && $urandom_range(99) < 13) idle_gap($urandom_range(1, 4));
      send_item(random_op());
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (model.errors == 0 && model.expected_beats.size() == 0)
      $display("** bicolor_matrix_frame_buffer: PASSED **");
    else
      $display("** bicolor_matrix_frame_buffer: FAILED **");
    $finish;
  end
endmodule
